/* hdl/shsd_pkg.sv */
// ============================================================================
// shsd_pkg: shared types and constants for the symbol hash sort/dedup block
// Item layouts for both channels, command codes and FNV-1a constants.
// ============================================================================
`default_nettype none

package shsd_pkg;

    localparam int MaxSymbols = 64;
    localparam int AddrW      = $clog2(MaxSymbols);
    localparam int CountW     = $clog2(MaxSymbols + 1);
    localparam int HashW      = 64;
    localparam int ValueW     = 63;
    localparam int BitsW      = 6;

    localparam logic [HashW-1:0] FnvBasis      = 64'hcbf29ce484222325;
    // The prime is 2^40 + 0x1b3, so the product is a shift plus a narrow multiply.
    localparam logic [8:0]       FnvPrimeLow   = 9'h1b3;
    localparam int               FnvPrimeShift = 40;

    localparam logic [BitsW-1:0] HashBitsReset = 6'd32;
    localparam logic [BitsW-1:0] HashBitsMin   = 6'd10;

    localparam logic [1:0] CMD_BYTE   = 2'd0;
    localparam logic [1:0] CMD_END    = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] sym_byte;
    } sym_item_t;

    typedef struct packed {
        logic [ValueW-1:0] hash_value;
        logic              is_last;
        logic              set_empty;
        logic              overflowed;
    } res_item_t;

endpackage

`default_nettype wire

/* hdl/symbol_hash_sort_dedup.sv */
// ============================================================================
// symbol_hash_sort_dedup: FNV-1a symbol hashing with sorted unique readout
// Hashes symbols byte by byte, stores masked hashes, emits them sorted/unique.
// ============================================================================
// Usage:
//   sym channel (sym_valid/sym_stall/sym_item): one command per item. A byte
//   item is XORed into the running hash, then multiplied by the prime in
//   ST_MUL; an end item writes the masked hash into the 64-entry store.
//   res channel (res_valid/res_stall/res_item): on a finish item the block
//   emits every unique stored hash in ascending order, is_last on the final
//   one. Readout repeats a scan of the store with one shared comparator pair:
//   each result takes a full pass over the n stored symbols.
//   A finish with no stored symbols gives one result with set_empty set.
//   The block takes no new item until the current one is fully handled.
//   A stalled result stays in the output register; the scan waits for it.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): hash_bits, reset value 32;
//   values below 10 act as 10. Written while the block is idle.
//   Reset: the store is empty, the running hash holds the offset basis.
// ============================================================================
`default_nettype none

module symbol_hash_sort_dedup (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sym_valid,
    output      logic                          sym_stall,
    input  wire shsd_pkg::sym_item_t           sym_item,
    output      logic                          res_valid,
    input  wire logic                          res_stall,
    output      shsd_pkg::res_item_t           res_item,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [shsd_pkg::BitsW-1:0]    cfg_data
);
    import shsd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCAN,
        ST_STEP,
        ST_EMPTY
    } state_t;

    state_t              state_reg, state_next;
    logic [HashW-1:0]    hash_reg, hash_next;
    logic [HashW-1:0]    x_reg, x_next;
    logic [BitsW-1:0]    bits_reg, bits_next;
    logic [CountW-1:0]   count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic                ov_reg, ov_next;
    logic [CountW-1:0]   n_reg, n_next;
    logic [CountW-1:0]   rd_addr_reg, rd_addr_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                found_reg, found_next;
    logic [ValueW-1:0]   best_reg, best_next;
    logic                have_low_reg, have_low_next;
    logic [ValueW-1:0]   low_reg, low_next;
    logic                res_valid_reg, res_valid_next;
    res_item_t           res_item_reg, res_item_next;

    logic [ValueW-1:0]   mem [MaxSymbols];
    logic [ValueW-1:0]   rd_data_reg;

    logic                accept;
    logic                slot_free;
    logic                mem_we;
    logic                mem_re;
    logic [BitsW-1:0]    bits_eff;
    logic [HashW-1:0]    keep_mask;
    logic [ValueW-1:0]   masked;
    logic                above_low;
    logic                below_best;

    assign accept    = sym_valid && !sym_stall;
    assign sym_stall = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign slot_free = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    assign bits_eff  = (bits_reg < HashBitsMin) ? HashBitsMin : bits_reg;
    assign keep_mask = ~({HashW{1'b1}} << bits_eff);
    assign masked    = ValueW'(hash_reg & keep_mask);

    assign mem_we = accept && (sym_item.command == CMD_END) && (count_reg < CountW'(MaxSymbols));
    assign mem_re = (state_reg == ST_SCAN) && (rd_addr_reg < n_reg);

    // Shared comparator pair: candidate must exceed the previous pass's minimum
    // and undercut the best candidate of the current pass.
    assign above_low  = !have_low_reg || (rd_data_reg > low_reg);
    assign below_best = !found_reg || (rd_data_reg < best_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[AddrW-1:0]] <= masked;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr_reg[AddrW-1:0]];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        x_next         = x_reg;
        bits_next      = bits_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        ov_next        = ov_reg;
        n_next         = n_reg;
        rd_addr_next   = rd_addr_reg;
        rd_pend_next   = rd_pend_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        have_low_next  = have_low_reg;
        low_next       = low_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_item_next  = res_item_reg;

        if (cfg_valid && cfg_ready)
        begin
            bits_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (sym_item.command)
                        CMD_BYTE:
                        begin
                            x_next     = hash_reg ^ {{(HashW-8){1'b0}}, sym_item.sym_byte};
                            state_next = ST_MUL;
                        end
                        CMD_END:
                        begin
                            if (mem_we)
                            begin
                                count_next = CountW'(count_reg + 1'b1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            hash_next = FnvBasis;
                        end
                        CMD_FINISH:
                        begin
                            ov_next       = ovf_reg;
                            n_next        = count_reg;
                            count_next    = '0;
                            ovf_next      = 1'b0;
                            hash_next     = FnvBasis;
                            rd_addr_next  = '0;
                            rd_pend_next  = 1'b0;
                            found_next    = 1'b0;
                            have_low_next = 1'b0;
                            state_next    = (count_reg == '0) ? ST_EMPTY : ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                hash_next  = (x_reg * FnvPrimeLow) + (x_reg << FnvPrimeShift);
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                rd_pend_next = mem_re;
                if (mem_re)
                begin
                    rd_addr_next = CountW'(rd_addr_reg + 1'b1);
                end
                if (rd_pend_reg && above_low && below_best)
                begin
                    best_next  = rd_data_reg;
                    found_next = 1'b1;
                end
                if (!mem_re && !rd_pend_reg)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (found_reg && !have_low_reg)
                begin
                    low_next      = best_reg;
                    have_low_next = 1'b1;
                    found_next    = 1'b0;
                    rd_addr_next  = '0;
                    state_next    = ST_SCAN;
                end
                else if (slot_free)
                begin
                    // The previous minimum is emitted once the next pass shows
                    // whether anything larger remains.
                    res_valid_next           = 1'b1;
                    res_item_next.hash_value = low_reg;
                    res_item_next.is_last    = !found_reg;
                    res_item_next.set_empty  = 1'b0;
                    res_item_next.overflowed = ov_reg;
                    if (found_reg)
                    begin
                        low_next     = best_reg;
                        found_next   = 1'b0;
                        rd_addr_next = '0;
                        state_next   = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (slot_free)
                begin
                    res_valid_next           = 1'b1;
                    res_item_next.hash_value = '0;
                    res_item_next.is_last    = 1'b1;
                    res_item_next.set_empty  = 1'b1;
                    res_item_next.overflowed = ov_reg;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= FnvBasis;
            x_reg         <= '0;
            bits_reg      <= HashBitsReset;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            ov_reg        <= 1'b0;
            n_reg         <= '0;
            rd_addr_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            have_low_reg  <= 1'b0;
            low_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            x_reg         <= x_next;
            bits_reg      <= bits_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            ov_reg        <= ov_next;
            n_reg         <= n_next;
            rd_addr_reg   <= rd_addr_next;
            rd_pend_reg   <= rd_pend_next;
            found_reg     <= found_next;
            best_reg      <= best_next;
            have_low_reg  <= have_low_next;
            low_reg       <= low_next;
            res_valid_reg <= res_valid_next;
            res_item_reg  <= res_item_next;
        end
    end

    // The store fill count never passes its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountW'(MaxSymbols))
    else $error("symbol count exceeds store capacity");

    // Each pass must find a value strictly above the previous minimum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && found_reg && have_low_reg) |-> (best_reg > low_reg))
    else $error("results would not be strictly ascending");

    // An empty-set result is a lone, zero-valued final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.set_empty) |-> (res_item.is_last && res_item.hash_value == '0))
    else $error("malformed empty-set result");

    // A new item is taken only after the readout has returned to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> sym_stall)
    else $error("input accepted during readout");

endmodule

`default_nettype wire
